// ===== rtl/core/md5h_pkg.sv =====
// MD5 byte-stream hasher: shared types, constants and round tables.
// Used by every module of the block; depends on nothing.
`default_nettype none
package md5h_pkg;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } md5h_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } md5h_out_t;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hEFCDAB89;
  localparam logic [31:0] IV_C = 32'h98BADCFE;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int unsigned QDEPTH = 4;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FILL,
    BK_ROUND,
    BK_ADD,
    BK_EMIT
  } bk_state_t;

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    begin
      case (r)
        6'd0: k = 32'hD76AA478; 6'd1: k = 32'hE8C7B756; 6'd2: k = 32'h242070DB;
        6'd3: k = 32'hC1BDCEEE; 6'd4: k = 32'hF57C0FAF; 6'd5: k = 32'h4787C62A;
        6'd6: k = 32'hA8304613; 6'd7: k = 32'hFD469501; 6'd8: k = 32'h698098D8;
        6'd9: k = 32'h8B44F7AF; 6'd10: k = 32'hFFFF5BB1; 6'd11: k = 32'h895CD7BE;
        6'd12: k = 32'h6B901122; 6'd13: k = 32'hFD987193; 6'd14: k = 32'hA679438E;
        6'd15: k = 32'h49B40821; 6'd16: k = 32'hF61E2562; 6'd17: k = 32'hC040B340;
        6'd18: k = 32'h265E5A51; 6'd19: k = 32'hE9B6C7AA; 6'd20: k = 32'hD62F105D;
        6'd21: k = 32'h02441453; 6'd22: k = 32'hD8A1E681; 6'd23: k = 32'hE7D3FBC8;
        6'd24: k = 32'h21E1CDE6; 6'd25: k = 32'hC33707D6; 6'd26: k = 32'hF4D50D87;
        6'd27: k = 32'h455A14ED; 6'd28: k = 32'hA9E3E905; 6'd29: k = 32'hFCEFA3F8;
        6'd30: k = 32'h676F02D9; 6'd31: k = 32'h8D2A4C8A; 6'd32: k = 32'hFFFA3942;
        6'd33: k = 32'h8771F681; 6'd34: k = 32'h6D9D6122; 6'd35: k = 32'hFDE5380C;
        6'd36: k = 32'hA4BEEA44; 6'd37: k = 32'h4BDECFA9; 6'd38: k = 32'hF6BB4B60;
        6'd39: k = 32'hBEBFBC70; 6'd40: k = 32'h289B7EC6; 6'd41: k = 32'hEAA127FA;
        6'd42: k = 32'hD4EF3085; 6'd43: k = 32'h04881D05; 6'd44: k = 32'hD9D4D039;
        6'd45: k = 32'hE6DB99E5; 6'd46: k = 32'h1FA27CF8; 6'd47: k = 32'hC4AC5665;
        6'd48: k = 32'hF4292244; 6'd49: k = 32'h432AFF97; 6'd50: k = 32'hAB9423A7;
        6'd51: k = 32'hFC93A039; 6'd52: k = 32'h655B59C3; 6'd53: k = 32'h8F0CCC92;
        6'd54: k = 32'hFFEFF47D; 6'd55: k = 32'h85845DD1; 6'd56: k = 32'h6FA87E4F;
        6'd57: k = 32'hFE2CE6E0; 6'd58: k = 32'hA3014314; 6'd59: k = 32'h4E0811A1;
        6'd60: k = 32'hF7537E82; 6'd61: k = 32'hBD3AF235; 6'd62: k = 32'h2AD7D2BB;
        default: k = 32'hEB86D391;
      endcase
      return k;
    end
  endfunction

  // Rotate amount by round group and round low bits.
  function automatic logic [4:0] round_s(input logic [5:0] r);
    logic [4:0] s;
    begin
      case ({r[5:4], r[1:0]})
        4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
        4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
        4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
        4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
      endcase
      return s;
    end
  endfunction

  // Message word index per round.
  function automatic logic [3:0] round_g(input logic [5:0] r);
    logic [3:0] g;
    logic [7:0] t;
    begin
      t = 8'd0;
      case (r[5:4])
        2'd0: t = {4'd0, r[3:0]};
        2'd1: t = 8'd5 * {2'd0, r} + 8'd1;
        2'd2: t = 8'd3 * {2'd0, r} + 8'd5;
        default: t = 8'd7 * {2'd0, r};
      endcase
      g = t[3:0];
      return g;
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/md5h_front.sv =====
// MD5 hasher front end: accepts items into a short transfer queue.
// Depends on md5h_pkg.
`default_nettype none
module md5h_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire md5h_pkg::md5h_in_t in_data,
  output logic                    q_valid,
  output md5h_pkg::md5h_in_t      q_data,
  input  wire logic               q_pop
);
  import md5h_pkg::*;

  localparam int AW = $clog2(QDEPTH);

  md5h_in_t       mem_r [QDEPTH];
  logic [AW-1:0]  wp_r, rp_r;
  logic [AW:0]    cnt_r;
  logic           push, pop;

  assign in_stall = (cnt_r == (AW+1)'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_data   = mem_r[rp_r];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_data;
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/md5h_back.sv =====
// MD5 hasher back end: block buffer, padding, 64-round compression, digest output.
// Depends on md5h_pkg.
`default_nettype none
module md5h_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  wire md5h_pkg::md5h_in_t q_data,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output md5h_pkg::md5h_out_t     out_data
);
  import md5h_pkg::*;

  bk_state_t    st_r, st_nxt;
  logic [31:0]  blk_r [16];
  logic [31:0]  h_r [4];
  logic [31:0]  a_r, b_r, c_r, d_r;
  logic [63:0]  cnt_r;
  logic [5:0]   rnd_r;
  logic [5:0]   fpos_r;      // padding fill position
  logic         fin_r;       // compressing for a finish
  logic         second_r;    // a length-only block follows
  logic [1:0]   widx_r;

  // Round datapath
  logic [31:0] f, sum, rot, msg;
  logic [4:0]  s;
  always_comb begin
    unique case (rnd_r[5:4])
      2'd0: f = d_r ^ (b_r & (c_r ^ d_r));
      2'd1: f = c_r ^ (d_r & (b_r ^ c_r));
      2'd2: f = b_r ^ c_r ^ d_r;
      default: f = c_r ^ (b_r | ~d_r);
    endcase
    msg = blk_r[round_g(rnd_r)];
    s   = round_s(rnd_r);
    sum = a_r + f + round_k(rnd_r) + msg;
    rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
  end

  logic [63:0] bits;
  assign bits = {cnt_r[60:0], 3'b000};

  assign q_pop     = (st_r == BK_IDLE) && q_valid;
  assign out_valid = (st_r == BK_EMIT);
  assign out_data  = '{digest_word: h_r[widx_r], word_index: widx_r,
                       last_word: (widx_r == 2'd3)};

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      BK_IDLE: begin
        if (q_valid) begin
          if (q_data.op == OP_FINISH) st_nxt = BK_FILL;
          else if (cnt_r[5:0] == 6'd63) st_nxt = BK_ROUND;
        end
      end
      BK_FILL:  if (fpos_r == 6'd63) st_nxt = BK_ROUND;
      BK_ROUND: if (rnd_r == 6'd63) st_nxt = BK_ADD;
      BK_ADD: begin
        if (second_r) st_nxt = BK_ROUND;
        else if (fin_r) st_nxt = BK_EMIT;
        else st_nxt = BK_IDLE;
      end
      BK_EMIT:  if (!out_stall && widx_r == 2'd3) st_nxt = BK_IDLE;
      default:  st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= BK_IDLE;
    else        st_r <= st_nxt;
  end

  // Control and chaining state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rnd_r    <= '0;
      fpos_r   <= '0;
      fin_r    <= 1'b0;
      second_r <= 1'b0;
      widx_r   <= '0;
      h_r[0] <= IV_A; h_r[1] <= IV_B; h_r[2] <= IV_C; h_r[3] <= IV_D;
    end else begin
      unique case (st_r)
        BK_IDLE: begin
          rnd_r <= '0;
          if (q_valid) begin
            if (q_data.op == OP_FINISH) begin
              fin_r  <= 1'b1;
              fpos_r <= cnt_r[5:0];
            end else begin
              fin_r <= 1'b0;
              cnt_r <= cnt_r + 64'd1;
            end
          end
        end
        BK_FILL: begin
          fpos_r <= fpos_r + 6'd1;
          if (fpos_r == 6'd63) second_r <= (cnt_r[5:0] >= 6'd56);
        end
        BK_ROUND: rnd_r <= rnd_r + 6'd1;
        BK_ADD: begin
          h_r[0] <= h_r[0] + a_r; h_r[1] <= h_r[1] + b_r;
          h_r[2] <= h_r[2] + c_r; h_r[3] <= h_r[3] + d_r;
          second_r <= 1'b0;
          widx_r   <= '0;
        end
        BK_EMIT: begin
          if (!out_stall) begin
            widx_r <= widx_r + 2'd1;
            if (widx_r == 2'd3) begin
              h_r[0] <= IV_A; h_r[1] <= IV_B; h_r[2] <= IV_C; h_r[3] <= IV_D;
              cnt_r <= '0;
              fin_r <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Working variables
  always_ff @(posedge clk) begin
    if (st_r == BK_ROUND) begin
      a_r <= d_r; d_r <= c_r; c_r <= b_r; b_r <= b_r + rot;
    end else begin
      a_r <= (st_r == BK_ADD) ? h_r[0] + a_r : h_r[0];
      b_r <= (st_r == BK_ADD) ? h_r[1] + b_r : h_r[1];
      c_r <= (st_r == BK_ADD) ? h_r[2] + c_r : h_r[2];
      d_r <= (st_r == BK_ADD) ? h_r[3] + d_r : h_r[3];
    end
  end

  // Block buffer writes
  always_ff @(posedge clk) begin
    if (st_r == BK_IDLE && q_valid && q_data.op == OP_APPEND) begin
      blk_r[cnt_r[5:2]][cnt_r[1:0]*8 +: 8] <= q_data.data_byte;
    end else if (st_r == BK_FILL) begin
      blk_r[fpos_r[5:2]][fpos_r[1:0]*8 +: 8] <=
        (fpos_r == cnt_r[5:0]) ? PAD_BYTE : 8'h00;
      if (fpos_r == 6'd63 && cnt_r[5:0] < 6'd56) begin
        blk_r[14] <= bits[31:0];
        blk_r[15] <= bits[63:32];
      end
    end else if (st_r == BK_ADD && second_r) begin
      for (int i = 0; i < 14; i++) blk_r[i] <= '0;
      blk_r[14] <= bits[31:0];
      blk_r[15] <= bits[63:32];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/md5_byte_stream_hasher.sv =====
// MD5 byte-stream hasher, top level: front queue feeding the compression back end.
// Operation: an append is stored in the block buffer, and one that completes a block starts
// 64 rounds in one shared round unit plus an add; a finish pads the block from its fill
// position, compresses one or two blocks, then gives 4 result transfers.
// Throughput: one byte per cycle inside a block while the back end is idle; a 4-entry
// queue decouples input. Reset (rst_n, sync, active low) loads the IV, clears count, queue.
`default_nettype none
module md5_byte_stream_hasher (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire md5h_pkg::md5h_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output md5h_pkg::md5h_out_t      out_data
);
  import md5h_pkg::*;

  logic     q_valid, q_pop;
  md5h_in_t q_data;

  md5h_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .q_valid, .q_data, .q_pop
  );

  md5h_back u_back (
    .clk, .rst_n, .q_valid, .q_data, .q_pop,
    .out_valid, .out_stall, .out_data
  );
endmodule
`default_nettype wire

// ===== rtl/core/md5h_checker.sv =====
// Port-level checker for the MD5 hasher, bound to the top level.
// Depends on md5h_pkg.
`default_nettype none
module md5h_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire md5h_pkg::md5h_out_t out_data
);
  import md5h_pkg::*;

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last_word == (out_data.word_index == 2'd3)))
    else $error("last_word mismatch");

  a_next_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_data.word_index != 2'd3) |=>
      (out_valid && out_data.word_index == $past(out_data.word_index) + 2'd1))
    else $error("digest words not consecutive");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_data.word_index == 2'd3) |=> !out_valid)
    else $error("result after last word");
endmodule

bind md5_byte_stream_hasher md5h_checker u_chk (
  .clk, .rst_n, .out_valid, .out_stall, .out_data
);
`default_nettype wire
